// File: src/utf8_to_utf16_decoder_top_assert.svh
// ---------------------------------------------------------------------------
// utf8 to utf16 decoder assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define U8U16_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 assertion failed");

// condition holds in the next cycle
`define U8U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 assertion failed");

`endif

// File: src/u8u16_pkg.sv
// ---------------------------------------------------------------------------
// u8u16_pkg
// types and codes shared by the utf8 to utf16 decoder
// ---------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [1:0] KIND_UNIT = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_BAD_CONT  = 3'd3;
    localparam logic [2:0] ERR_BAD_CP    = 3'd4;
    localparam logic [2:0] ERR_OVERLONG  = 3'd5;

    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [20:0] SURR_LO        = 21'h00D800;
    localparam logic [20:0] SURR_HI        = 21'h00DFFF;
    localparam logic [15:0] SURR_LEAD_BIAS = 16'hD7C0;
    localparam logic [5:0]  TRAIL_PREFIX   = 6'b110111;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  bytes_remaining;
        logic [2:0]  seq_bytes;
        logic [20:0] code_point_accum;
        logic        failed;
    } dec_state_t;

    typedef struct packed {
        dec_state_t  state;
        logic [1:0]  count;
        result_t     res0;
        result_t     res1;
    } dec_out_t;

endpackage

// File: src/u8u16_decode.sv
// ---------------------------------------------------------------------------
// u8u16_decode
// combinational step: one utf8 byte plus decoder state to results and next state
// ---------------------------------------------------------------------------
module u8u16_decode
(
    input  logic [7:0]             data_byte,
    input  u8u16_pkg::dec_state_t  state,
    output u8u16_pkg::dec_out_t    dec
);

    localparam u8u16_pkg::dec_state_t STATE_CLEAR = '0;

    logic [20:0] acc_shift;
    logic [20:0] cp;
    logic [2:0]  cp_len;
    logic        do_emit;
    logic        cp_bad;
    logic        overlong;
    logic [15:0] lead_unit;

    assign acc_shift = {state.code_point_accum[14:0], data_byte[5:0]};

    // candidate code point: finished sequence or a single ascii byte
    assign cp     = (state.bytes_remaining != 2'd0) ? acc_shift : {13'd0, data_byte};
    assign cp_len = (state.bytes_remaining != 2'd0) ? state.seq_bytes : 3'd1;

    always_comb
    begin
        do_emit = 1'b0;
        dec     = '0;
        dec.state = state;

        if (state.failed)
        begin
            if (data_byte == 8'd0)
            begin
                dec.state.failed = 1'b0;
            end
        end
        else if (state.bytes_remaining != 2'd0)
        begin
            if (data_byte == 8'd0)
            begin
                dec.state           = STATE_CLEAR;
                dec.count           = 2'd1;
                dec.res0.kind       = u8u16_pkg::KIND_ERR;
                dec.res0.error_code = u8u16_pkg::ERR_TRUNCATED;
                dec.res0.last       = 1'b1;
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                dec.state           = STATE_CLEAR;
                dec.state.failed    = 1'b1;
                dec.count           = 2'd1;
                dec.res0.kind       = u8u16_pkg::KIND_ERR;
                dec.res0.error_code = u8u16_pkg::ERR_BAD_CONT;
                dec.res0.last       = 1'b1;
            end
            else if (state.bytes_remaining == 2'd1)
            begin
                do_emit = 1'b1;
            end
            else
            begin
                dec.state.code_point_accum = acc_shift;
                dec.state.bytes_remaining  = state.bytes_remaining - 2'd1;
            end
        end
        else if (data_byte == 8'd0)
        begin
            dec.state     = STATE_CLEAR;
            dec.count     = 2'd1;
            dec.res0.kind = u8u16_pkg::KIND_END;
            dec.res0.last = 1'b1;
        end
        else if (data_byte[7] == 1'b0)
        begin
            do_emit = 1'b1;
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            dec.state.seq_bytes        = 3'd2;
            dec.state.bytes_remaining  = 2'd1;
            dec.state.code_point_accum = {16'd0, data_byte[4:0]};
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            dec.state.seq_bytes        = 3'd3;
            dec.state.bytes_remaining  = 2'd2;
            dec.state.code_point_accum = {17'd0, data_byte[3:0]};
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            dec.state.seq_bytes        = 3'd4;
            dec.state.bytes_remaining  = 2'd3;
            dec.state.code_point_accum = {18'd0, data_byte[2:0]};
        end
        else
        begin
            dec.state           = STATE_CLEAR;
            dec.state.failed    = 1'b1;
            dec.count           = 2'd1;
            dec.res0.kind       = u8u16_pkg::KIND_ERR;
            dec.res0.error_code = u8u16_pkg::ERR_BAD_LEAD;
            dec.res0.last       = 1'b1;
        end

        if (do_emit)
        begin
            dec.state = STATE_CLEAR;
            dec.count = 2'd1;
            if (cp_bad || overlong)
            begin
                dec.state.failed    = 1'b1;
                dec.res0.kind       = u8u16_pkg::KIND_ERR;
                dec.res0.error_code = cp_bad ? u8u16_pkg::ERR_BAD_CP
                                             : u8u16_pkg::ERR_OVERLONG;
                dec.res0.last       = 1'b1;
            end
            else if (cp[20:16] != 5'd0)
            begin
                dec.count          = 2'd2;
                dec.res0.code_unit = lead_unit;
                dec.res1.code_unit = {u8u16_pkg::TRAIL_PREFIX, cp[9:0]};
                dec.res1.last      = 1'b1;
            end
            else
            begin
                dec.res0.code_unit = cp[15:0];
                dec.res0.last      = 1'b1;
            end
        end
    end

    assign cp_bad = (cp > u8u16_pkg::CP_MAX)
                 || ((cp >= u8u16_pkg::SURR_LO) && (cp <= u8u16_pkg::SURR_HI));

    always_comb
    begin
        if (cp[20:7] == 14'd0)
        begin
            overlong = (cp_len != 3'd1);
        end
        else if (cp[20:11] == 10'd0)
        begin
            overlong = (cp_len != 3'd2);
        end
        else if (cp[20:16] == 5'd0)
        begin
            overlong = (cp_len != 3'd3);
        end
        else
        begin
            overlong = 1'b0;
        end
    end

    assign lead_unit = {5'd0, cp[20:10]} + u8u16_pkg::SURR_LEAD_BIAS;

endmodule

// File: src/utf8_to_utf16_decoder_top.sv
// byte path: input stage register, combinational decode, then the result queue
// throughput: one byte per cycle while the queue has room, set by the single result port
// the port gives one result per cycle; a surrogate pair byte puts two results on it
// the four-entry result queue takes a byte while earlier results wait to be taken
// reset: rst_n asynchronous, clears decoder state, input stage and queue (empty)
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// utf8 byte stream to utf16 code units with coded error results
// ---------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_top_assert.svh"

module utf8_to_utf16_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic [1:0]  kind,
    output logic [2:0]  error_code,
    output logic        last
);

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;
    u8u16_pkg::dec_state_t      state_reg;
    u8u16_pkg::dec_out_t        dec;
    u8u16_pkg::result_t         queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W:0]             count_reg;
    logic [PTR_W:0]             count_next;
    logic [PTR_W:0]             push_n;
    logic                       pop;
    logic                       s1_fire;
    u8u16_pkg::result_t         head;

    u8u16_decode u_decode
    (
        .data_byte (s1_byte_reg),
        .state     (state_reg),
        .dec       (dec)
    );

    assign pop       = out_valid && out_ready;
    assign s1_fire   = s1_valid_reg
                    && ((count_reg <= (PTR_W+1)'(QUEUE_DEPTH - 2))
                     || ((count_reg == (PTR_W+1)'(QUEUE_DEPTH - 1)) && pop));
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign push_n    = s1_fire ? {{(PTR_W-1){1'b0}}, dec.count} : '0;
    assign count_next = count_reg + push_n - {{PTR_W{1'b0}}, pop};

    assign head       = queue_reg[rd_ptr_reg];
    assign out_valid  = (count_reg != '0);
    assign code_unit  = head.code_unit;
    assign kind       = head.kind;
    assign error_code = head.error_code;
    assign last       = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                state_reg  <= dec.state;
                wr_ptr_reg <= wr_ptr_reg + push_n[PTR_W-1:0];
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
        end
        if (s1_fire && (dec.count != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= dec.res0;
        end
        if (s1_fire && (dec.count == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= dec.res1;
        end
    end

    // assertions
    `U8U16_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
    `U8U16_ASSERT_SAME(a_failed_silent, s1_fire && state_reg.failed, dec.count == 2'd0)
    `U8U16_ASSERT_SAME(a_pair_last, s1_fire && (dec.count == 2'd2), dec.res1.last && !dec.res0.last)
    `U8U16_ASSERT_NEXT(a_pair_queued, s1_fire && (dec.count == 2'd2), count_reg >= (PTR_W+1)'(2))
    `U8U16_ASSERT_SAME(a_stall_cause, !in_ready, s1_valid_reg && (count_reg != '0))

endmodule
